[hdl/string_hash_djb2_park_miller_core_defines.svh]
// Assertion macros shared by the string hash core modules.
`ifndef STRING_HASH_DJB2_PARK_MILLER_CORE_DEFINES_SVH
`define STRING_HASH_DJB2_PARK_MILLER_CORE_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define SHPM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define SHPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/shpm_pkg.sv]
// Package with the constants and types of the string hash core.
`timescale 1ns / 1ps

package shpm_pkg;

  localparam int unsigned AccW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TblW     = 5;
  localparam int unsigned BucketW  = 31;
  localparam int unsigned MultW    = 15;
  localparam int unsigned ProdW    = AccW + MultW;

  localparam logic [AccW-1:0]  HashSeed       = 32'd5381;
  localparam int unsigned      DjbShift       = 5;
  localparam logic [TblW-1:0]  TableSizeReset = 5'd10;
  localparam logic [MultW-1:0] PmMult         = 15'd16807;
  localparam logic [AccW-1:0]  PmModulus      = 32'h7fff_ffff;
  // 2^32 is congruent to 2 modulo 2^31-1, so a negative operand costs 2*16807.
  localparam logic [ProdW-1:0] PmNegCorr      = 47'd33614;
  localparam logic [ByteW-1:0] KeyTerminator  = 8'd0;

  // Occupancy flags of the queue between front and back.
  typedef struct packed {
    logic not_full;
    logic not_empty;
  } shpm_q_status_t;

endpackage

[hdl/shpm_front.sv]
// Front end: accepts key bytes, runs the djb2 accumulation, queues finished keys.
`timescale 1ns / 1ps

module shpm_front
  import shpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ByteW-1:0]     key_byte_i,
  input  shpm_q_status_t       q_status_i,
  output logic                 push_o,
  output logic [AccW-1:0]      push_data_o
);

  logic [AccW-1:0] acc_q, acc_d;
  logic            is_term;
  logic            accept;

  assign is_term    = (key_byte_i == KeyTerminator);
  // Ordinary bytes never wait; only a terminator needs room in the queue.
  assign in_ready_o = !is_term || q_status_i.not_full;
  assign accept     = in_valid_i && in_ready_o;

  assign push_o      = accept && is_term;
  assign push_data_o = acc_q;

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      if (is_term) begin
        acc_d = HashSeed;
      end else begin
        acc_d = (acc_q << DjbShift) + acc_q + AccW'(key_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= HashSeed;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

[hdl/shpm_fifo.sv]
// Short register queue carrying finished accumulators from front to back.
`timescale 1ns / 1ps
`include "string_hash_djb2_park_miller_core_defines.svh"

module shpm_fifo
  import shpm_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [AccW-1:0] data_i,
  input  logic            pop_i,
  output logic [AccW-1:0] data_o,
  output shpm_q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [AccW-1:0] slot_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.not_full  = (cnt_q != CntW'(Depth));
  assign status_o.not_empty = (cnt_q != '0);
  assign do_push = push_i && status_o.not_full;
  assign do_pop  = pop_i && status_o.not_empty;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `SHPM_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count exceeds depth")
  `SHPM_ASSERT_ALWAYS(a_no_overflow, !(push_i && !status_o.not_full), "push into full queue")

endmodule

[hdl/shpm_back.sv]
// Back end: Park-Miller step as a multiply, fold and reduce pipeline with output register.
`timescale 1ns / 1ps
`include "string_hash_djb2_park_miller_core_defines.svh"

module shpm_back
  import shpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  shpm_q_status_t     q_status_i,
  input  logic [AccW-1:0]    q_data_i,
  output logic               pop_o,
  input  logic [TblW-1:0]    table_size_log2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [AccW-1:0]    hash_value_o,
  output logic [BucketW-1:0] bucket_index_o
);

  logic               adv;
  logic               s1_valid_q, s1_neg_q;
  logic [ProdW-1:0]   s1_prod_q;
  logic               s2_valid_q;
  logic [AccW-1:0]    s2_sum_q;
  logic               out_valid_q;
  logic [AccW-1:0]    hash_q;
  logic [BucketW-1:0] bucket_q;

  logic [ProdW-1:0]   corr_prod;
  logic [AccW-1:0]    fold_sum;
  logic [AccW-1:0]    hash_d;
  logic [AccW-1:0]    mask_full;

  // The whole pipeline moves together; it halts only while a result waits.
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && q_status_i.not_empty;

  // Fold the product modulo 2^31-1: high part plus low part.
  always_comb begin
    corr_prod = s1_prod_q - (s1_neg_q ? PmNegCorr : '0);
    fold_sum  = AccW'(corr_prod[30:0]) + AccW'(corr_prod[ProdW-1:31]);
  end

  // The fold stays below twice the modulus; a zero residue maps to the modulus itself.
  always_comb begin
    if (s2_sum_q == '0) begin
      hash_d = PmModulus;
    end else if (s2_sum_q > PmModulus) begin
      hash_d = s2_sum_q - PmModulus;
    end else begin
      hash_d = s2_sum_q;
    end
    mask_full = (32'd1 << table_size_log2_i) - 32'd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q <= ProdW'(q_data_i) * ProdW'(PmMult);
      s1_neg_q  <= q_data_i[AccW-1];
      s2_sum_q  <= fold_sum;
      hash_q    <= hash_d;
      bucket_q  <= hash_d[BucketW-1:0] & mask_full[BucketW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_status_i.not_empty;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hash_value_o   = hash_q;
  assign bucket_index_o = bucket_q;

  `SHPM_ASSERT_ALWAYS(a_fold_bound, !s2_valid_q || (s2_sum_q < 32'h8001_0000), "fold out of range")
  `SHPM_ASSERT_ALWAYS(a_hash_range, !out_valid_q || (!hash_q[AccW-1] && hash_q != '0), "hash out of range")
  `SHPM_ASSERT_ALWAYS(a_bucket_sub, !out_valid_q || ((bucket_q & ~hash_q[BucketW-1:0]) == '0), "bucket not a subset of hash")
  `SHPM_ASSERT_NEXT(a_s2_to_out, s2_valid_q && adv, out_valid_q, "result lost in last stage")

endmodule

[hdl/string_hash_djb2_park_miller_core.sv]
// Top level of the djb2 string hash core with Park-Miller finishing step.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   -------------------------------
//   input     in_valid_i/in_ready_o   key_byte_i
//   output    out_valid_o/out_ready_i hash_value_o, bucket_index_o
//   config    cfg_we_i (no wait)      cfg_wdata_i (table_size_log2)
//
// One key byte is taken each cycle unless a terminator waits for queue room; the rate
// is set by the accumulator update loop (shift by five, add, add byte) in the front end.
// A terminator's result passes in order through the queue, the multiply stage,
// the fold stage and the output register.
// Reset loads the accumulator with 5381, empties the queue and the pipeline,
// and sets table_size_log2 to 10.
// Output stalls freeze the back pipeline; the front keeps accepting bytes and
// only a terminator waits when the queue between front and back is full.
`timescale 1ns / 1ps

module string_hash_djb2_park_miller_core
  import shpm_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TblW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   key_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [AccW-1:0]    hash_value_o,
  output logic [BucketW-1:0] bucket_index_o
);

  // The single configuration register. The user must write it only while the core is idle;
  // the core does not enforce this. The back end reads it directly to form the bucket index.
  logic [TblW-1:0] table_size_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_log2_q <= TableSizeReset;
    end else if (cfg_we_i) begin
      table_size_log2_q <= cfg_wdata_i;
    end
  end

  shpm_q_status_t  q_status;
  logic            push;
  logic [AccW-1:0] push_data;
  logic            pop;
  logic [AccW-1:0] q_data;

  // Front end: every byte transaction updates the accumulator; a terminator
  // hands the finished accumulator to the queue and reloads the seed.
  shpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_byte_i  (key_byte_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // The queue decouples the two halves so that a stalled output does not
  // hold up the byte stream until the queue fills.
  shpm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_data),
    .pop_i    (pop),
    .data_o   (q_data),
    .status_o (q_status)
  );

  // Back end: the Schrage step equals 16807*r modulo 2^31-1 with a zero
  // residue replaced by the modulus, computed here by multiply and fold.
  shpm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_status_i        (q_status),
    .q_data_i          (q_data),
    .pop_o             (pop),
    .table_size_log2_i (table_size_log2_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hash_value_o      (hash_value_o),
    .bucket_index_o    (bucket_index_o)
  );

endmodule
